// ===== rtl/core/eew_pkg.sv =====
// ----------------------------------------------------------------------------
// eew_pkg
// Shared widths, event codes and result type of the element walker.
// ----------------------------------------------------------------------------
package eew_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 32;
	localparam int KIND_W = 3;
	localparam int VINT_W = 56;

	localparam logic [KIND_W-1:0] EV_HEADER    = 3'd0;
	localparam logic [KIND_W-1:0] EV_SIGNATURE = 3'd1;
	localparam logic [KIND_W-1:0] EV_INVALID   = 3'd2;
	localparam logic [KIND_W-1:0] EV_OVERFLOW  = 3'd3;
	localparam logic [KIND_W-1:0] EV_END       = 3'd4;

	localparam logic [VINT_W-1:0] ID_HEADER    = 56'h0A45DFA3;
	localparam logic [VINT_W-1:0] ID_SIGNATURE = 56'h5345414C;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [LEN_W-1:0]  payload_start;
		logic [LEN_W-1:0]  payload_end;
		logic [LEN_W-1:0]  insert_offset;
	} result_t;

endpackage

// ===== rtl/core/eew_byte_if.sv =====
// ----------------------------------------------------------------------------
// eew_byte_if
// Valid/ready channel carrying one file byte per item.
// ----------------------------------------------------------------------------
interface eew_byte_if;
	import eew_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);

endinterface

// ===== rtl/core/eew_event_if.sv =====
// ----------------------------------------------------------------------------
// eew_event_if
// Valid/ready channel carrying one walker event per item.
// ----------------------------------------------------------------------------
interface eew_event_if;
	import eew_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [LEN_W-1:0]  payload_start;
	logic [LEN_W-1:0]  payload_end;
	logic [LEN_W-1:0]  insert_offset;

	modport source (output valid, output event_kind, output payload_start,
		output payload_end, output insert_offset, input ready);
	modport sink (input valid, input event_kind, input payload_start,
		input payload_end, input insert_offset, output ready);

endinterface

// ===== rtl/core/ebml_element_walker.sv =====
// ----------------------------------------------------------------------------
// ebml_element_walker
// Walks the top-level elements of an EBML byte stream and reports header
// and signature payload ranges, stops and end of file.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in takes one file byte per item, in file order. event_out gives
//   events: header, signature, invalid stop, overflow stop, end reached.
//   cfg_wr_en/cfg_wr_data write total_length and restart the walk; write it
//   while the block is idle, before the first byte of a file.
// Timing:
//   one byte is accepted every cycle while byte_in.ready is high; the state
//   update for a byte is done in the cycle it is accepted, and its events
//   (zero, one or two) are pushed into a four-entry result queue, from
//   which event_out gives them in order. byte_in.ready is high while the
//   queue has at least two free entries, so a byte that yields two events
//   always finds room in the queue.
// Reset and stall:
//   arst_n clears the walk, total_length and the queue. When event_out is
//   stalled the queue fills and byte_in.ready drops; no event is lost.
//   After a stop or the end event further bytes are accepted and dropped.
// ----------------------------------------------------------------------------
module ebml_element_walker #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [eew_pkg::LEN_W-1:0] cfg_wr_data,
	eew_byte_if.sink                 byte_in,
	eew_event_if.source              event_out
);
	import eew_pkg::*;

	localparam logic [1:0] PH_ID   = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam int CW    = (OFFSET_BITS > LEN_W + 1) ? OFFSET_BITS : LEN_W + 1;
	localparam int QD    = 4;
	localparam int PTR_W = $clog2(QD);
	localparam int CNT_W = PTR_W + 1;

	logic [1:0]             phase_q, phase_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [2:0]             left_q, left_d;
	logic [VINT_W-1:0]      acc_q, acc_d;
	logic [VINT_W-1:0]      id_q, id_d;
	logic [LEN_W-1:0]       skip_q, skip_d;
	logic [LEN_W-1:0]       lip_q, lip_d;
	logic [LEN_W-1:0]       total_q;

	result_t                res_a, res_b;
	logic                   push_a, push_b, stop;

	logic                   take;
	logic [BYTE_W-1:0]      b;
	logic [2:0]             lz;
	logic [VINT_W-1:0]      take_acc;
	logic [2:0]             take_left;
	logic [OFFSET_BITS-1:0] pos_inc, end_v;
	logic [LEN_W:0]         start33, room;
	logic                   ovf, is_hdr, is_sig;

	result_t                mem_q [QD];
	logic [PTR_W-1:0]       wr_q, rd_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pop;

	assign b    = byte_in.data_byte;
	assign take = byte_in.valid && byte_in.ready;
	assign pop  = event_out.valid && event_out.ready;

	// leading zeros of the lead byte, capped at seven
	always_comb begin
		lz = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (b[7-i]) begin
				lz = 3'(i);
			end
		end
	end

	always_comb begin
		if (left_q == 3'd0) begin
			take_acc  = VINT_W'(b & (8'h7F >> lz));
			take_left = lz;
		end else begin
			take_acc  = {acc_q[VINT_W-9:0], b};
			take_left = left_q - 3'd1;
		end
	end

	assign pos_inc = pos_q + 1'b1;
	assign start33 = (LEN_W + 1)'(pos_inc);
	assign room    = {1'b0, total_q} - start33;
	assign ovf     = take_acc > VINT_W'(room);
	assign end_v   = pos_inc + OFFSET_BITS'(take_acc);
	assign is_hdr  = id_q == ID_HEADER;
	assign is_sig  = id_q == ID_SIGNATURE;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		left_d  = left_q;
		acc_d   = acc_q;
		id_d    = id_q;
		skip_d  = skip_q;
		lip_d   = lip_q;
		push_a  = 1'b0;
		push_b  = 1'b0;
		res_a   = '0;
		res_b   = '0;
		stop    = 1'b0;
		if (take && phase_q != PH_DONE) begin
			if (CW'(pos_q) >= CW'(total_q)) begin
				phase_d = PH_DONE;
				push_a  = 1'b1;
				res_a   = '{EV_END, '0, '0, lip_q};
			end else begin
				if (phase_q == PH_SKIP) begin
					skip_d = skip_q - 1'b1;
					if (skip_d == '0) begin
						phase_d = PH_ID;
					end
				end else if (left_q == 3'd0 && b == '0) begin
					phase_d = PH_DONE;
					pos_d   = pos_inc;
					stop    = 1'b1;
					push_a  = 1'b1;
					res_a   = '{EV_INVALID, '0, '0, lip_q};
				end else begin
					acc_d  = take_acc;
					left_d = take_left;
					if (take_left == 3'd0) begin
						if (phase_q == PH_ID) begin
							id_d    = take_acc;
							phase_d = PH_LEN;
						end else if (ovf) begin
							phase_d = PH_DONE;
							pos_d   = pos_inc;
							stop    = 1'b1;
							push_a  = 1'b1;
							res_a   = '{EV_OVERFLOW, LEN_W'(pos_inc), '0, lip_q};
						end else begin
							if (is_hdr || is_sig) begin
								lip_d  = LEN_W'(end_v);
								push_a = 1'b1;
								res_a  = '{is_hdr ? EV_HEADER : EV_SIGNATURE,
									LEN_W'(pos_inc), LEN_W'(end_v), LEN_W'(end_v)};
							end
							skip_d  = LEN_W'(take_acc);
							phase_d = (take_acc == '0) ? PH_ID : PH_SKIP;
						end
					end
				end
				if (!stop) begin
					pos_d = pos_inc;
					if (CW'(pos_inc) >= CW'(total_q)) begin
						phase_d = PH_DONE;
						if (push_a) begin
							push_b = 1'b1;
							res_b  = '{EV_END, '0, '0, lip_d};
						end else begin
							push_a = 1'b1;
							res_a  = '{EV_END, '0, '0, lip_d};
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			phase_q <= PH_ID;
			pos_q   <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			id_q    <= '0;
			skip_q  <= '0;
			lip_q   <= '0;
		end else if (cfg_wr_en) begin
			total_q <= cfg_wr_data;
			phase_q <= PH_ID;
			pos_q   <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			id_q    <= '0;
			skip_q  <= '0;
			lip_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			id_q    <= id_d;
			skip_q  <= skip_d;
			lip_q   <= lip_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= res_a;
		end
		if (push_b) begin
			mem_q[wr_q + 1'b1] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_a) + PTR_W'(push_b);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
		end
	end

	assign byte_in.ready           = count_q <= CNT_W'(QD - 2);
	assign event_out.valid         = count_q != '0;
	assign event_out.event_kind    = mem_q[rd_q].event_kind;
	assign event_out.payload_start = mem_q[rd_q].payload_start;
	assign event_out.payload_end   = mem_q[rd_q].payload_end;
	assign event_out.insert_offset = mem_q[rd_q].insert_offset;

endmodule

// ===== rtl/core/eew_checker.sv =====
// ----------------------------------------------------------------------------
// eew_checker
// Port-level checks on the event channel of the element walker.
// ----------------------------------------------------------------------------
module eew_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [eew_pkg::KIND_W-1:0] event_kind,
	input logic [eew_pkg::LEN_W-1:0]  payload_start,
	input logic [eew_pkg::LEN_W-1:0]  payload_end,
	input logic [eew_pkg::LEN_W-1:0]  insert_offset
);
	import eew_pkg::*;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind)
		&& $stable(payload_start) && $stable(payload_end) && $stable(insert_offset))
		else $error("stalled event changed");

	// nothing pending while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("event valid during reset");

	// element events move the insert point to their payload end, which lies no earlier than their start
	a_elem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_HEADER || event_kind == EV_SIGNATURE)
		|-> insert_offset == payload_end && payload_start <= payload_end)
		else $error("element event range mismatch");

	// of the stop and end events, only an overflow stop reports a position, as payload_start
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_INVALID || event_kind == EV_END
		|| event_kind == EV_OVERFLOW) |-> payload_end == '0
		&& (event_kind == EV_OVERFLOW || payload_start == '0))
		else $error("stop event carries a range");

endmodule

bind ebml_element_walker eew_checker u_eew_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (event_out.valid),
	.out_ready     (event_out.ready),
	.event_kind    (event_out.event_kind),
	.payload_start (event_out.payload_start),
	.payload_end   (event_out.payload_end),
	.insert_offset (event_out.insert_offset)
);
